>>> hdl/kdns_pkg.sv
package kdns_pkg;

    localparam int COORD_W = 16;
    localparam int POS_W   = 10;
    localparam int DIM_W   = 3;
    localparam int CNT_W   = 11;
    localparam int CMD_W   = 2;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BOX   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SPLIT = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

    localparam logic KIND_SPLIT = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic [POS_W-1:0]          position;
        logic [DIM_W-1:0]          dimension;
        logic signed [COORD_W-1:0] coord_value;
        logic signed [COORD_W-1:0] box_high_value;
        logic [POS_W-1:0]          point_id;
        logic [CNT_W-1:0]          point_count;
    } kdns_in_t;

    typedef struct packed {
        logic                      result_kind;
        logic [DIM_W-1:0]          cut_dimension;
        logic signed [COORD_W-1:0] cut_value;
        logic [CNT_W-1:0]          low_count;
        logic [POS_W-1:0]          read_id;
    } kdns_out_t;

endpackage

>>> hdl/kdns_in_if.sv
interface kdns_in_if
    import kdns_pkg::*;
();
    logic     valid;
    logic     ready;
    kdns_in_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/kdns_out_if.sv
interface kdns_out_if
    import kdns_pkg::*;
();
    logic      valid;
    logic      ready;
    kdns_out_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/kd_tree_node_split.sv
// kd-tree cell splitter. Loads (command 0) and box writes (command 1) give no
// beat; a read-back (command 3) gives one beat after the id memory read. A
// split (command 2) is run by a sequencer around one shared compare unit and a
// single-port id memory: an axis pick over the DIMENSIONS box edges, a min/max
// scan, and two partition passes. Stores are not cleared at reset.
module kd_tree_node_split
    import kdns_pkg::*;
#(
    parameter int MAX_POINTS = 1024,
    parameter int DIMENSIONS = 3
)(
    input  logic        clk,
    input  logic        rst_n,
    kdns_in_if.sink     in_ch,
    kdns_out_if.source  out_ch
);
    localparam int DW  = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
    localparam int AW  = $clog2(MAX_POINTS);
    localparam int IW  = AW + 2;                  // signed index, holds -1..MAX
    localparam int CA  = $clog2(MAX_POINTS * DIMENSIONS);
    localparam int CTW = $clog2(MAX_POINTS + 1);

    localparam logic [4:0] S_IDLE  = 5'd0,  S_AXIS  = 5'd1,  S_MID   = 5'd2,
                           S_MMA   = 5'd3,  S_MMB   = 5'd4,  S_MMC   = 5'd5,
                           S_LA    = 5'd6,  S_LB    = 5'd7,  S_LC    = 5'd8,
                           S_RA    = 5'd9,  S_RB    = 5'd10, S_RC    = 5'd11,
                           S_SW1   = 5'd12, S_SW2   = 5'd13, S_SW3   = 5'd14,
                           S_FIN   = 5'd15, S_OUT   = 5'd16, S_RDA   = 5'd17,
                           S_RDB   = 5'd18;

    logic signed [COORD_W-1:0] coord_mem [MAX_POINTS*DIMENSIONS];
    logic [POS_W-1:0]          id_mem [MAX_POINTS];
    logic signed [COORD_W-1:0] blo_reg [DIMENSIONS];
    logic signed [COORD_W-1:0] bhi_reg [DIMENSIONS];

    logic [4:0]                state_reg, state_next;
    logic                      pass_reg, pass_next;
    logic [DW-1:0]             d_reg, d_next, cdim_reg, cdim_next;
    logic signed [COORD_W:0]   best_reg, best_next;
    logic signed [COORD_W-1:0] ideal_reg, ideal_next, thr_reg, thr_next;
    logic signed [COORD_W-1:0] mn_reg, mn_next, mx_reg, mx_next;
    logic signed [IW-1:0]      l_reg, l_next, r_reg, r_next, n_reg, n_next;
    logic signed [IW-1:0]      br1_reg, br1_next, br2_reg, br2_next;
    logic [POS_W-1:0]          idl_reg, idl_next;
    logic [POS_W-1:0]          idr_reg;
    kdns_out_t                 res_reg, res_next;
    logic                      ov_reg, ov_next;

    // id memory port
    logic                      idw_en;
    logic [AW-1:0]             id_addr;
    logic [POS_W-1:0]          idw_data, idq_reg;
    // coordinate memory read
    logic [CA-1:0]             c_addr;
    logic signed [COORD_W-1:0] cq_reg;
    logic                      cq_ok;

    kdns_in_t                  req;
    logic [CNT_W-1:0]          cnt_c;
    logic signed [COORD_W:0]   edge_c, sum_c;
    logic signed [IW-1:0]      half_c, n_ext;

    assign req = in_ch.payload;
    assign in_ch.ready  = (state_reg == S_IDLE) && !ov_reg;
    assign out_ch.valid = ov_reg;
    assign out_ch.payload = res_reg;

    wire acc = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk)
    begin
        if (acc && req.command == CMD_LOAD && 32'(req.position) < MAX_POINTS
            && 32'(req.point_id) < MAX_POINTS && 32'(req.dimension) < DIMENSIONS)
        begin
            coord_mem[CA'(32'(req.point_id) * DIMENSIONS + 32'(req.dimension))]
                <= req.coord_value;
        end
        if (acc && req.command == CMD_BOX && 32'(req.dimension) < DIMENSIONS)
        begin
            blo_reg[DW'(req.dimension)] <= req.coord_value;
            bhi_reg[DW'(req.dimension)] <= req.box_high_value;
        end
        cq_reg <= coord_mem[c_addr];
        if (idw_en)
        begin
            id_mem[id_addr] <= idw_data;
        end
        idq_reg <= id_mem[id_addr];
    end

    // id read at l or r (or the request position); coordinate read from the
    // registered id read result
    always_comb
    begin
        idw_en   = 1'b0;
        idw_data = idl_reg;
        id_addr  = AW'(r_reg);
        if (acc && req.command == CMD_LOAD && 32'(req.position) < MAX_POINTS
            && 32'(req.point_id) < MAX_POINTS && 32'(req.dimension) < DIMENSIONS)
        begin
            idw_en = 1'b1;
            idw_data = req.point_id;
            id_addr = AW'(req.position);
        end
        else if (acc)
        begin
            id_addr = AW'(req.position);
        end
        else if (state_reg == S_MMA || state_reg == S_LA || state_reg == S_SW1)
        begin
            id_addr = AW'(l_reg);
        end
        if (state_reg == S_SW2)
        begin
            idw_en = 1'b1;
            idw_data = idr_reg;
            id_addr = AW'(l_reg);
        end
        else if (state_reg == S_SW3)
        begin
            idw_en = 1'b1;
            idw_data = idl_reg;
            id_addr = AW'(r_reg);
        end
        c_addr = CA'(32'(idq_reg) * DIMENSIONS + 32'(cdim_reg));
    end

    assign cq_ok = 32'(idq_reg) < MAX_POINTS;
    wire signed [COORD_W-1:0] cval = cq_ok ? cq_reg : '0;

    assign cnt_c = (req.point_count == '0) ? CNT_W'(1) :
                   (32'(req.point_count) > MAX_POINTS) ? CNT_W'(MAX_POINTS) :
                   req.point_count;
    assign edge_c = (COORD_W+1)'(bhi_reg[d_reg]) - (COORD_W+1)'(blo_reg[d_reg]);
    assign sum_c  = (COORD_W+1)'(bhi_reg[cdim_reg]) + (COORD_W+1)'(blo_reg[cdim_reg]);
    assign n_ext  = n_reg;
    assign half_c = n_ext >>> 1;

    // shared compare: value at l/r against threshold
    logic cmp_lt, cmp_le;
    assign cmp_lt = cval < thr_reg;
    assign cmp_le = cval <= thr_reg;
    wire l_adv = pass_reg ? cmp_le : cmp_lt;   // keep moving l
    wire r_adv = pass_reg ? !cmp_le : !cmp_lt; // keep moving r
    wire signed [IW-1:0] r_floor = pass_reg ? br1_reg : '0;

    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        d_next     = d_reg;
        cdim_next  = cdim_reg;
        best_next  = best_reg;
        ideal_next = ideal_reg;
        thr_next   = thr_reg;
        mn_next    = mn_reg;
        mx_next    = mx_reg;
        l_next     = l_reg;
        r_next     = r_reg;
        n_next     = n_reg;
        br1_next   = br1_reg;
        br2_next   = br2_reg;
        idl_next   = idl_reg;
        res_next   = res_reg;
        ov_next    = ov_reg;
        if (ov_reg && out_ch.ready)
        begin
            ov_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc && req.command == CMD_SPLIT)
                begin
                    n_next = IW'(cnt_c);
                    d_next = '0;
                    cdim_next = '0;
                    state_next = S_AXIS;
                end
                else if (acc && req.command == CMD_READ)
                begin
                    l_next = (32'(req.position) < MAX_POINTS) ? IW'(0) : IW'(-1);
                    state_next = S_RDA;
                end
            end
            S_RDA:
            begin
                // idq holds the requested id only for this cycle
                idl_next = idq_reg;
                state_next = S_RDB;
            end
            S_RDB:
            begin
                res_next = '0;
                res_next.result_kind = KIND_READ;
                res_next.read_id = (l_reg == '0) ? idl_reg : '0;
                ov_next = 1'b1;
                state_next = S_IDLE;
            end
            S_AXIS:
            begin
                if (d_reg == '0 || best_reg < edge_c)
                begin
                    best_next = edge_c;
                    cdim_next = d_reg;
                end
                if (32'(d_reg) == DIMENSIONS - 1)
                begin
                    state_next = S_MID;
                end
                else
                begin
                    d_next = d_reg + DW'(1);
                end
            end
            S_MID:
            begin
                ideal_next = COORD_W'((sum_c + (COORD_W+1)'(sum_c < 0)) >>> 1);
                l_next = '0;
                state_next = S_MMA;
            end
            S_MMA:
                state_next = S_MMB;    // id read
            S_MMB:
                state_next = S_MMC;    // coord read
            S_MMC:
            begin
                if (l_reg == '0)
                begin
                    mn_next = cval;
                    mx_next = cval;
                end
                else
                begin
                    if (cval < mn_reg) mn_next = cval;
                    if (cval >= mx_reg) mx_next = cval;
                end
                if (l_reg == n_reg - IW'(1))
                begin
                    l_next = '0;
                    r_next = n_reg - IW'(1);
                    pass_next = 1'b0;
                    state_next = S_FIN;
                end
                else
                begin
                    l_next = l_reg + IW'(1);
                    state_next = S_MMA;
                end
            end
            S_FIN:
            begin
                // threshold set once; partition starts
                thr_next = (ideal_reg < mn_reg) ? mn_reg :
                           (ideal_reg > mx_reg) ? mx_reg : ideal_reg;
                state_next = S_LA;
            end
            S_LA:
            begin
                if (l_reg >= n_reg) state_next = S_RA;
                else state_next = S_LB;
            end
            S_LB:
                state_next = S_LC;
            S_LC:
            begin
                if (l_adv)
                begin
                    l_next = l_reg + IW'(1);
                    state_next = S_LA;
                end
                else
                begin
                    state_next = S_RA;
                end
            end
            S_RA:
            begin
                if (r_reg < r_floor) state_next = S_SW1;
                else state_next = S_RB;
            end
            S_RB:
                state_next = S_RC;
            S_RC:
            begin
                if (r_adv)
                begin
                    r_next = r_reg - IW'(1);
                    state_next = S_RA;
                end
                else
                begin
                    state_next = S_SW1;
                end
            end
            S_SW1:
            begin
                if (l_reg > r_reg)
                begin
                    if (!pass_reg)
                    begin
                        br1_next = l_reg;
                        r_next = n_reg - IW'(1);
                        pass_next = 1'b1;
                        state_next = S_LA;
                    end
                    else
                    begin
                        br2_next = l_reg;
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    state_next = S_SW2;    // reads id[l]
                end
            end
            S_SW2:
            begin
                // idq holds id[l]; id[r] from idr goes into l
                idl_next = idq_reg;
                state_next = S_SW3;
            end
            S_SW3:
            begin
                l_next = l_reg + IW'(1);
                r_next = r_reg - IW'(1);
                state_next = S_LA;
            end
            S_OUT:
            begin
                res_next = '0;
                res_next.result_kind = KIND_SPLIT;
                res_next.cut_dimension = DIM_W'(cdim_reg);
                res_next.cut_value = thr_reg;
                if (ideal_reg < mn_reg)
                    res_next.low_count = CNT_W'(1);
                else if (ideal_reg > mx_reg)
                    res_next.low_count = CNT_W'(n_reg - IW'(1));
                else if (br1_reg > half_c)
                    res_next.low_count = CNT_W'(br1_reg);
                else if (br2_reg < half_c)
                    res_next.low_count = CNT_W'(br2_reg);
                else
                    res_next.low_count = CNT_W'(half_c);
                ov_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Swap: the right-side compare in S_RC ends with idq = id[r], kept in idr.
    // S_SW1 reads id[l], S_SW2 writes idr into l, S_SW3 writes id[l] into r.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_RC || state_reg == S_LC)
        begin
            idr_reg <= idq_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            pass_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            pass_reg  <= pass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg     <= d_next;
        cdim_reg  <= cdim_next;
        best_reg  <= best_next;
        ideal_reg <= ideal_next;
        thr_reg   <= thr_next;
        mn_reg    <= mn_next;
        mx_reg    <= mx_next;
        l_reg     <= l_next;
        r_reg     <= r_next;
        n_reg     <= n_next;
        br1_reg   <= br1_next;
        br2_reg   <= br2_next;
        res_reg   <= res_next;
        // swap: id[l] captured in SW2 (read issued in SW1); written to r in SW3
        // while SW2 writes the stored id[r] into l
        if (state_reg == S_SW2)
            idl_reg <= idq_reg;
        else
            idl_reg <= idl_next;
    end

    a_rdy_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> (state_reg == S_IDLE))
        else $error("ready outside idle");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> out_ch.valid)
        else $error("result dropped");
    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |-> (br1_reg <= br2_reg && br2_reg <= n_reg))
        else $error("partition bounds broken");
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && req.command == CMD_SPLIT) |=> (state_reg == S_AXIS))
        else $error("split did not start");
endmodule
